/* sv/sync_length_crc16_frame_receiver_unit_assert.svh */
// assertion macros for the frame receiver checker
// expects clk and rst_n in the scope where a macro is used
`ifndef SYNC_LENGTH_CRC16_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define SYNC_LENGTH_CRC16_FRAME_RECEIVER_UNIT_ASSERT_SVH

// same-cycle implication
`define SLCFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/slcfr_pkg.sv */
// shared types, constants and crc step function for the frame receiver
// no dependencies
`default_nettype none

package slcfr_pkg;

    localparam int RESULT_CAP = 59;

    localparam logic [7:0]  SYNC_BYTE_RST   = 8'd52;
    localparam logic [15:0] CRC_POLY_RST    = 16'd4129;
    localparam logic [15:0] CRC_SEED_RST    = 16'hFFFF;
    localparam logic [5:0]  MAX_PAYLOAD_RST = 6'd59;

    localparam logic [1:0] REG_SYNC_BYTE   = 2'd0;
    localparam logic [1:0] REG_CRC_POLY    = 2'd1;
    localparam logic [1:0] REG_CRC_SEED    = 2'd2;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd3;

    typedef enum logic [5:0] {
        S_HUNT      = 6'b000001,
        S_LEN       = 6'b000010,
        S_DATA      = 6'b000100,
        S_CRC_LO    = 6'b001000,
        S_CRC_HI    = 6'b010000,
        S_EMIT_RD   = 6'b100000
    } state_t;

    typedef struct packed {
        logic crc_seed_ld;
        logic crc_feed_en;
        logic len_ld;
        logic data_wr;
        logic crc_lo_ld;
        logic emit_clr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic sync_hit;
        logic len_ok;
        logic data_done;
        logic crc_ok;
        logic emit_last;
        logic out_free;
    } status_t;

    // one byte through the crc, msb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/slcfr_ctrl.sv */
// frame parse and burst controller state machine
// depends on slcfr_pkg
`default_nettype none

module slcfr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire slcfr_pkg::status_t sts,
    output logic                   in_stall,
    output slcfr_pkg::cmd_t        cmd
);

    slcfr_pkg::state_t state_reg;
    slcfr_pkg::state_t state_next;
    logic              wait_reg;
    logic              wait_next;
    logic              acc;

    assign in_stall = (state_reg == slcfr_pkg::S_EMIT_RD) || wait_reg;
    assign acc      = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        cmd        = '0;
        unique case (state_reg)
            slcfr_pkg::S_HUNT:
            begin
                if (acc && sts.sync_hit)
                begin
                    cmd.crc_seed_ld = 1'b1;
                    state_next      = slcfr_pkg::S_LEN;
                end
            end
            slcfr_pkg::S_LEN:
            begin
                if (acc)
                begin
                    if (sts.len_ok)
                    begin
                        cmd.len_ld      = 1'b1;
                        cmd.crc_feed_en = 1'b1;
                        state_next      = slcfr_pkg::S_DATA;
                    end
                    else
                    begin
                        state_next = slcfr_pkg::S_HUNT;
                    end
                end
            end
            slcfr_pkg::S_DATA:
            begin
                if (acc)
                begin
                    cmd.data_wr     = 1'b1;
                    cmd.crc_feed_en = 1'b1;
                    if (sts.data_done)
                    begin
                        state_next = slcfr_pkg::S_CRC_LO;
                    end
                end
            end
            slcfr_pkg::S_CRC_LO:
            begin
                if (acc)
                begin
                    cmd.crc_lo_ld = 1'b1;
                    state_next    = slcfr_pkg::S_CRC_HI;
                end
            end
            slcfr_pkg::S_CRC_HI:
            begin
                if (acc)
                begin
                    if (sts.crc_ok)
                    begin
                        cmd.emit_clr = 1'b1;
                        state_next   = slcfr_pkg::S_EMIT_RD;
                    end
                    else
                    begin
                        state_next = slcfr_pkg::S_HUNT;
                    end
                end
            end
            slcfr_pkg::S_EMIT_RD:
            begin
                if (!wait_reg)
                begin
                    wait_next = 1'b1;
                end
                else if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    wait_next    = 1'b0;
                    if (sts.emit_last)
                    begin
                        state_next = slcfr_pkg::S_HUNT;
                    end
                end
            end
            default:
            begin
                state_next = slcfr_pkg::S_HUNT;
                wait_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slcfr_pkg::S_HUNT;
            wait_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
        end
    end

endmodule

`default_nettype wire

/* sv/slcfr_dpath.sv */
// config registers, crc, payload store and output register
// depends on slcfr_pkg
`default_nettype none

module slcfr_dpath #(
    parameter int BUFFER_BYTES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              out_stall,
    input  wire slcfr_pkg::cmd_t   cmd,
    output slcfr_pkg::status_t     sts,
    output logic                   out_valid,
    output logic [7:0]             payload_byte,
    output logic [5:0]             byte_index,
    output logic [5:0]             payload_length,
    output logic                   last
);

    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int LIM_CAP_INT = (BUFFER_BYTES < slcfr_pkg::RESULT_CAP) ?
                                 BUFFER_BYTES : slcfr_pkg::RESULT_CAP;
    localparam logic [5:0] LIM_CAP = 6'(LIM_CAP_INT);

    logic [7:0]  sync_byte_reg;
    logic [15:0] crc_poly_reg;
    logic [15:0] crc_seed_reg;
    logic [5:0]  max_payload_reg;

    logic [15:0] crc_reg;
    logic [7:0]  crc_lo_reg;
    logic [5:0]  frame_len_reg;
    logic [5:0]  bytes_seen_reg;
    logic [5:0]  rd_idx_reg;
    logic [7:0]  rd_data_reg;

    logic        out_valid_reg;
    logic [7:0]  payload_byte_reg;
    logic [5:0]  byte_index_reg;
    logic [5:0]  payload_length_reg;
    logic        last_reg;

    logic [7:0]  payload_mem [BUFFER_BYTES];

    logic [5:0]  limit_len;
    logic [15:0] crc_in;
    logic [15:0] crc_step;
    logic [5:0]  seen_inc;
    logic [5:0]  rd_inc;

    assign limit_len = (max_payload_reg > LIM_CAP) ? LIM_CAP : max_payload_reg;
    assign crc_in    = cmd.crc_seed_ld ? crc_seed_reg : crc_reg;
    assign crc_step  = slcfr_pkg::crc_feed(crc_in, rx_byte, crc_poly_reg);
    assign seen_inc  = bytes_seen_reg + 6'd1;
    assign rd_inc    = rd_idx_reg + 6'd1;

    assign sts.sync_hit  = (rx_byte == sync_byte_reg);
    assign sts.len_ok    = (rx_byte != 8'd0) && (rx_byte <= {2'b00, limit_len});
    assign sts.data_done = (seen_inc >= frame_len_reg);
    assign sts.crc_ok    = ({rx_byte, crc_lo_reg} == crc_reg);
    assign sts.emit_last = (rd_inc == frame_len_reg);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg   <= slcfr_pkg::SYNC_BYTE_RST;
            crc_poly_reg    <= slcfr_pkg::CRC_POLY_RST;
            crc_seed_reg    <= slcfr_pkg::CRC_SEED_RST;
            max_payload_reg <= slcfr_pkg::MAX_PAYLOAD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                slcfr_pkg::REG_SYNC_BYTE:   sync_byte_reg   <= cfg_data[7:0];
                slcfr_pkg::REG_CRC_POLY:    crc_poly_reg    <= cfg_data;
                slcfr_pkg::REG_CRC_SEED:    crc_seed_reg    <= cfg_data;
                slcfr_pkg::REG_MAX_PAYLOAD: max_payload_reg <= cfg_data[5:0];
                default:                    sync_byte_reg   <= sync_byte_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= '0;
            crc_lo_reg     <= '0;
            frame_len_reg  <= '0;
            bytes_seen_reg <= '0;
            rd_idx_reg     <= '0;
        end
        else
        begin
            if (cmd.crc_seed_ld || cmd.crc_feed_en)
            begin
                crc_reg <= crc_step;
            end
            if (cmd.len_ld)
            begin
                frame_len_reg  <= rx_byte[5:0];
                bytes_seen_reg <= '0;
            end
            else if (cmd.data_wr)
            begin
                bytes_seen_reg <= seen_inc;
            end
            if (cmd.crc_lo_ld)
            begin
                crc_lo_reg <= rx_byte;
            end
            if (cmd.emit_clr)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.out_load)
            begin
                rd_idx_reg <= rd_inc;
            end
        end
    end

    // payload store, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.data_wr)
        begin
            payload_mem[ADDR_W'(bytes_seen_reg)] <= rx_byte;
        end
        rd_data_reg <= payload_mem[ADDR_W'(rd_idx_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            payload_byte_reg   <= rd_data_reg;
            byte_index_reg     <= rd_idx_reg;
            payload_length_reg <= frame_len_reg;
            last_reg           <= sts.emit_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign payload_byte   = payload_byte_reg;
    assign byte_index     = byte_index_reg;
    assign payload_length = payload_length_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

/* sv/sync_length_crc16_frame_receiver_unit.sv */
// top level of the sync/length/crc-16 frame receiver
// depends on slcfr_pkg, slcfr_ctrl and slcfr_dpath
//
// input channel: rx_byte with in_valid/in_stall, one word per received byte
// output channel: payload_byte, byte_index, payload_length, last with
//   out_valid/out_stall, one word per payload byte of a frame whose crc matched
// config port: cfg_we, cfg_index, cfg_data; write only while the block is idle
// while parsing, a byte is taken every cycle; the crc update for each sync,
//   length and payload byte is done in the cycle it is taken
// after the crc high byte the input stalls while the payload store replays
//   the frame: each word is loaded only after a wait state that lets the
//   registered read of the store catch up, so words never come back to back
// a held out_stall freezes the output register and the burst; the input is
//   taken again once the last word is loaded, even if it still waits
// bad length or bad crc drops the frame with no output
// reset returns to sync hunting with default register values; the store
//   needs no clearing
`default_nettype none

module sync_length_crc16_frame_receiver_unit #(
    parameter int BUFFER_BYTES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       payload_byte,
    output logic [5:0]       byte_index,
    output logic [5:0]       payload_length,
    output logic             last
);

    slcfr_pkg::cmd_t    cmd;
    slcfr_pkg::status_t sts;

    slcfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    slcfr_dpath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rx_byte        (rx_byte),
        .out_stall      (out_stall),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_valid),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .payload_length (payload_length),
        .last           (last)
    );

endmodule

`default_nettype wire

/* sv/slcfr_checker.sv */
// port-level assertions for the frame receiver, bound to the top level
// depends on sync_length_crc16_frame_receiver_unit_assert.svh
`default_nettype none
`include "sync_length_crc16_frame_receiver_unit_assert.svh"

module slcfr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  payload_byte,
    input wire logic [5:0]  byte_index,
    input wire logic [5:0]  payload_length,
    input wire logic        last
);

    logic        out_held;
    logic [20:0] out_word;
    logic        last_due;

    assign out_held = out_valid && out_stall;
    assign out_word = {payload_byte, byte_index, payload_length, last};
    assign last_due = ((byte_index + 6'd1) == payload_length);

    `SLCFR_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "stalled word changed")
    `SLCFR_ASSERT_NOW(a_burst_stalls_in, out_valid && !last, in_stall, "input taken during a burst")
    `SLCFR_ASSERT_NOW(a_index_range, out_valid, byte_index < payload_length, "byte index beyond length")
    `SLCFR_ASSERT_NOW(a_last_flag, out_valid, last == last_due, "last flag mismatch")

endmodule

bind sync_length_crc16_frame_receiver_unit slcfr_checker u_slcfr_checker (.*);

`default_nettype wire
